FILE: rtl/core/abs_slip_band_pressure_fsm_macros.svh
// Assertion macros used by the slip-band pressure modulator top level.
`ifndef ABS_SLIP_BAND_PRESSURE_FSM_MACROS_SVH
`define ABS_SLIP_BAND_PRESSURE_FSM_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while reset is asserted.
`define ASBP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is asserted.
`define ASBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/asbp_pkg.sv
// Shared types and constants for the slip-band pressure modulator.
`default_nettype none
package asbp_pkg;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned APB_W   = 32;

    // Phase codes as they appear on the result beat.
    localparam logic [PHASE_W-1:0] PHASE_NORMAL = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_BUILD  = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_HOLD   = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_DUMP   = 2'd3;

    // Register indexes (word address bits of paddr).
    localparam logic [2:0] REG_SPEED_CUTOFF     = 3'd0;
    localparam logic [2:0] REG_SLIP_HIGH        = 3'd1;
    localparam logic [2:0] REG_SLIP_BAND_TOP    = 3'd2;
    localparam logic [2:0] REG_SLIP_BAND_BOTTOM = 3'd3;
    localparam logic [2:0] REG_SLIP_RELEASE     = 3'd4;
    localparam logic [2:0] REG_BUILD_INCREMENT  = 3'd5;
    localparam logic [2:0] REG_DUMP_DECREMENT   = 3'd6;
    localparam logic [2:0] REG_PRESSURE_FLOOR   = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] driver_pressure;
        logic [DATA_W-1:0] wheel_slip;
        logic [DATA_W-1:0] vehicle_speed;
    } in_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0]  brake_pressure;
        logic [PHASE_W-1:0] phase;
    } out_beat_t;

    typedef struct packed {
        logic [DATA_W-1:0] speed_cutoff;
        logic [DATA_W-1:0] slip_high;
        logic [DATA_W-1:0] slip_band_top;
        logic [DATA_W-1:0] slip_band_bottom;
        logic [DATA_W-1:0] slip_release;
        logic [DATA_W-1:0] build_increment;
        logic [DATA_W-1:0] dump_decrement;
        logic [DATA_W-1:0] pressure_floor;
    } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/abs_slip_band_pressure_fsm.sv
// Top level of the ABS slip-band pressure modulator: handshake pipeline and wiring.
// An accepted input beat passes the input register and then the output register to reach m_data.
// Throughput: one beat per cycle while m_ready stays high; both the input and output registers advance together.
// The phase machine and held pressure update in the cycle a beat leaves the input register.
// Reset (aresetn, synchronous, active low): pipeline empty, phase normal, held pressure zero,
// and all configuration registers return to their default thresholds and steps.
`default_nettype none
`include "abs_slip_band_pressure_fsm_macros.svh"
module abs_slip_band_pressure_fsm
    import asbp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Sample channel.
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire in_beat_t          s_data,
    // Result channel.
    output logic                   m_valid,
    input  wire logic              m_ready,
    output out_beat_t              m_data,
    // Configuration port.
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [APB_W-1:0]  pwdata,
    output logic      [APB_W-1:0]  prdata,
    output logic                   pready
);

    cfg_t      cfg;
    in_beat_t  in_data_reg;
    logic      in_valid_reg;
    out_beat_t out_data_reg;
    logic      out_valid_reg;
    out_beat_t step_result;
    logic      advance;
    logic      s_fire;

    asbp_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // A beat in the input register moves on whenever the output register is
    // free or is being emptied this cycle; the state update rides on that move.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    // The input register takes a new beat if it is empty or its beat moves on.
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    asbp_modulator u_modulator (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; the valid flags guard them.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Below the speed cutoff the command passes through in normal phase.
    `ASBP_ASSERT_NEXT(a_low_speed_pass,
        advance && (in_data_reg.vehicle_speed < cfg.speed_cutoff),
        m_data.phase == PHASE_NORMAL
            && m_data.brake_pressure == $past(in_data_reg.driver_pressure),
        "low speed beat did not pass the command through")
    // The modulated pressure never exceeds the driver command.
    `ASBP_ASSERT_NEXT(a_cmd_ceiling,
        advance,
        m_valid && m_data.brake_pressure <= $past(in_data_reg.driver_pressure),
        "brake pressure above driver command")
    // The sample channel stalls only when both pipeline registers are held.
    `ASBP_ASSERT_NOW(a_stall_cause,
        !s_ready,
        in_valid_reg && out_valid_reg && !m_ready,
        "sample channel stalled without a full pipeline")

endmodule
`default_nettype wire

FILE: rtl/core/asbp_cfg_regs.sv
// APB register bank holding the modulator thresholds and step sizes.
`default_nettype none
module asbp_cfg_regs
    import asbp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [APB_W-1:0]  pwdata,
    output logic      [APB_W-1:0]  prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  reg_idx;
    logic [DATA_W-1:0] wr_val;
    logic [DATA_W-1:0] rd_val;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign wr_val  = pwdata[DATA_W-1:0];
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.speed_cutoff     <= 16'd1280;
            cfg_reg.slip_high        <= 16'd19661;
            cfg_reg.slip_band_top    <= 16'd16384;
            cfg_reg.slip_band_bottom <= 16'd9830;
            cfg_reg.slip_release     <= 16'd6554;
            cfg_reg.build_increment  <= 16'd26;
            cfg_reg.dump_decrement   <= 16'd51;
            cfg_reg.pressure_floor   <= 16'd0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SPEED_CUTOFF:     cfg_reg.speed_cutoff     <= wr_val;
                REG_SLIP_HIGH:        cfg_reg.slip_high        <= wr_val;
                REG_SLIP_BAND_TOP:    cfg_reg.slip_band_top    <= wr_val;
                REG_SLIP_BAND_BOTTOM: cfg_reg.slip_band_bottom <= wr_val;
                REG_SLIP_RELEASE:     cfg_reg.slip_release     <= wr_val;
                REG_BUILD_INCREMENT:  cfg_reg.build_increment  <= wr_val;
                REG_DUMP_DECREMENT:   cfg_reg.dump_decrement   <= wr_val;
                REG_PRESSURE_FLOOR:   cfg_reg.pressure_floor   <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SPEED_CUTOFF:     rd_val = cfg_reg.speed_cutoff;
            REG_SLIP_HIGH:        rd_val = cfg_reg.slip_high;
            REG_SLIP_BAND_TOP:    rd_val = cfg_reg.slip_band_top;
            REG_SLIP_BAND_BOTTOM: rd_val = cfg_reg.slip_band_bottom;
            REG_SLIP_RELEASE:     rd_val = cfg_reg.slip_release;
            REG_BUILD_INCREMENT:  rd_val = cfg_reg.build_increment;
            REG_DUMP_DECREMENT:   rd_val = cfg_reg.dump_decrement;
            REG_PRESSURE_FLOOR:   rd_val = cfg_reg.pressure_floor;
            default:              rd_val = '0;
        endcase
        prdata = {{(APB_W-DATA_W){1'b0}}, rd_val};
    end

endmodule
`default_nettype wire

FILE: rtl/core/asbp_modulator.sv
// Phase machine and held-pressure register with the clamped pressure update.
`default_nettype none
module asbp_modulator
    import asbp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     advance,
    input  wire in_beat_t item,
    input  wire cfg_t     cfg,
    output out_beat_t     result
);

    typedef enum logic [PHASE_W-1:0] {
        ST_NORMAL = PHASE_NORMAL,
        ST_BUILD  = PHASE_BUILD,
        ST_HOLD   = PHASE_HOLD,
        ST_DUMP   = PHASE_DUMP
    } state_t;

    state_t            mode_reg, mode_next, fsm_next;
    logic [DATA_W-1:0] held_reg, held_next;
    logic              low_speed;
    logic              over_high, over_top, under_bottom, under_release;
    // One sign bit and one carry bit above the 16-bit pressure.
    logic signed [DATA_W+1:0] p_raw, p_floor, p_clamp;
    logic signed [DATA_W+1:0] cmd_s, floor_s;

    assign low_speed     = item.vehicle_speed < cfg.speed_cutoff;
    assign over_high     = item.wheel_slip > cfg.slip_high;
    assign over_top      = item.wheel_slip > cfg.slip_band_top;
    assign under_bottom  = item.wheel_slip < cfg.slip_band_bottom;
    assign under_release = item.wheel_slip < cfg.slip_release;

    // Test order matters: in build the band top is checked before slip_high.
    always_comb begin
        case (mode_reg)
            ST_NORMAL: begin
                if (over_high)         fsm_next = ST_DUMP;
                else if (over_top)     fsm_next = ST_HOLD;
                else if (under_bottom) fsm_next = ST_BUILD;
                else                   fsm_next = ST_NORMAL;
            end
            ST_BUILD: begin
                if (over_top)          fsm_next = ST_HOLD;
                else if (over_high)    fsm_next = ST_DUMP;
                else                   fsm_next = ST_BUILD;
            end
            ST_HOLD: begin
                if (over_high)         fsm_next = ST_DUMP;
                else if (under_bottom) fsm_next = ST_BUILD;
                else                   fsm_next = ST_HOLD;
            end
            ST_DUMP: begin
                if (under_release)     fsm_next = ST_BUILD;
                else                   fsm_next = ST_DUMP;
            end
            default:                   fsm_next = ST_NORMAL;
        endcase
    end

    always_comb begin
        cmd_s   = signed'({2'b00, item.driver_pressure});
        floor_s = signed'({2'b00, cfg.pressure_floor});
        case (fsm_next)
            ST_NORMAL: p_raw = cmd_s;
            ST_BUILD:  p_raw = signed'({2'b00, held_reg}) + signed'({2'b00, cfg.build_increment});
            ST_HOLD:   p_raw = signed'({2'b00, held_reg});
            ST_DUMP:   p_raw = signed'({2'b00, held_reg}) - signed'({2'b00, cfg.dump_decrement});
            default:   p_raw = cmd_s;
        endcase
        // Floor first, then the command, so a low command overrides the floor.
        p_floor = (p_raw < floor_s) ? floor_s : p_raw;
        p_clamp = (p_floor > cmd_s) ? cmd_s : p_floor;

        if (low_speed) begin
            mode_next = ST_NORMAL;
            held_next = item.driver_pressure;
        end else begin
            mode_next = fsm_next;
            held_next = p_clamp[DATA_W-1:0];
        end
        result.brake_pressure = held_next;
        result.phase          = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ST_NORMAL;
            held_reg <= '0;
        end else if (advance) begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the ABS slip-band pressure modulator.
`timescale 1ns / 1ps
module tb_top;
    import asbp_pkg::*;

    // Clocking, reset and run limits.
    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 11;
    // Quiet after the last owed result makes sure nothing is left in flight
    // before a register write.
    localparam int DRAIN_CYCLES = 4;
    localparam int MAX_REPORTS  = 10;
    localparam int MAX_GAP      = 16;
    localparam int HOLD_OFF     = 200;
    localparam int SEGMENTS     = 20;
    localparam int SEG_SAMPLES  = 60;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int NUM_REGS     = 8;

    // Register values after reset.
    localparam logic [DATA_W-1:0] DEF_SPEED_CUTOFF     = 16'd1280;
    localparam logic [DATA_W-1:0] DEF_SLIP_HIGH        = 16'd19661;
    localparam logic [DATA_W-1:0] DEF_SLIP_BAND_TOP    = 16'd16384;
    localparam logic [DATA_W-1:0] DEF_SLIP_BAND_BOTTOM = 16'd9830;
    localparam logic [DATA_W-1:0] DEF_SLIP_RELEASE     = 16'd6554;
    localparam logic [DATA_W-1:0] DEF_BUILD_INCREMENT  = 16'd26;
    localparam logic [DATA_W-1:0] DEF_DUMP_DECREMENT   = 16'd51;
    localparam logic [DATA_W-1:0] DEF_PRESSURE_FLOOR   = 16'd0;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    in_beat_t          s_data;
    logic              m_valid;
    logic              m_ready;
    out_beat_t         m_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    // Our own copy of the register file and of the modulator state.
    logic [DATA_W-1:0]  model_regs [NUM_REGS];
    logic [PHASE_W-1:0] model_phase;
    logic [DATA_W-1:0]  model_held;

    // Pressure/phase pairs owed by the block, oldest first.
    out_beat_t pending_results [$];

    int   mismatches       = 0;
    int   cycle_count      = 0;
    int   send_idle_pct    = 0;
    int   recv_stall_pct   = 0;
    int   hold_off_request = 0;
    logic hold_off_active  = 1'b0;

    abs_slip_band_pressure_fsm i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Runs one sample through the phase machine and the pressure clamp and
    // returns the beat the block must produce for it. The state moves on here,
    // so this is called exactly once per accepted input beat.
    function automatic out_beat_t modulate_sample(in_beat_t b);
        int        p;
        out_beat_t r;
        if (b.vehicle_speed < model_regs[REG_SPEED_CUTOFF]) begin
            // Modulation is off: the command passes through, no floor applied.
            model_phase = PHASE_NORMAL;
            model_held  = b.driver_pressure;
        end else begin
            // The order of the tests matters; BUILD looks at the band top
            // before the high threshold, so a very large slip holds first.
            case (model_phase)
                PHASE_NORMAL: begin
                    if (b.wheel_slip > model_regs[REG_SLIP_HIGH]) begin
                        model_phase = PHASE_DUMP;
                    end else if (b.wheel_slip > model_regs[REG_SLIP_BAND_TOP]) begin
                        model_phase = PHASE_HOLD;
                    end else if (b.wheel_slip < model_regs[REG_SLIP_BAND_BOTTOM]) begin
                        model_phase = PHASE_BUILD;
                    end
                end
                PHASE_BUILD: begin
                    if (b.wheel_slip > model_regs[REG_SLIP_BAND_TOP]) begin
                        model_phase = PHASE_HOLD;
                    end else if (b.wheel_slip > model_regs[REG_SLIP_HIGH]) begin
                        model_phase = PHASE_DUMP;
                    end
                end
                PHASE_HOLD: begin
                    if (b.wheel_slip > model_regs[REG_SLIP_HIGH]) begin
                        model_phase = PHASE_DUMP;
                    end else if (b.wheel_slip < model_regs[REG_SLIP_BAND_BOTTOM]) begin
                        model_phase = PHASE_BUILD;
                    end
                end
                default: begin
                    if (b.wheel_slip < model_regs[REG_SLIP_RELEASE]) begin
                        model_phase = PHASE_BUILD;
                    end
                end
            endcase
            // The step is formed in a 32-bit signed value so it cannot wrap.
            case (model_phase)
                PHASE_NORMAL: p = int'(b.driver_pressure);
                PHASE_BUILD:  p = int'(model_held) + int'(model_regs[REG_BUILD_INCREMENT]);
                PHASE_HOLD:   p = int'(model_held);
                default:      p = int'(model_held) - int'(model_regs[REG_DUMP_DECREMENT]);
            endcase
            // Floor first, then the command; the command wins when it is lower.
            if (p < int'(model_regs[REG_PRESSURE_FLOOR])) begin
                p = int'(model_regs[REG_PRESSURE_FLOOR]);
            end
            if (p > int'(b.driver_pressure)) begin
                p = int'(b.driver_pressure);
            end
            model_held = p[DATA_W-1:0];
        end
        r.brake_pressure = model_held;
        r.phase          = model_phase;
        return r;
    endfunction

    task automatic report_mismatch(string what, int unsigned want, int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Scoreboard. Both sides are sampled on the rising edge, before the block's
    // registers move. A result beat is checked before the input beat of the same
    // edge is predicted; a beat passes the input and output registers first, so the two never belong together.
    always @(posedge aclk) begin : scoreboard
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat", 0, m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data.brake_pressure !== want.brake_pressure) begin
                    report_mismatch("brake_pressure", want.brake_pressure, m_data.brake_pressure);
                end
                if (m_data.phase !== want.phase) begin
                    report_mismatch("phase", want.phase, m_data.phase);
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            pending_results.push_back(modulate_sample(s_data));
        end
    end

    // Watchdog: a hung handshake must not hang the run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("abs_slip_band_pressure_fsm verification failed");
            $finish;
        end
    end

    // Result side: random stalls at the current rate, or a solid hold-off while
    // the pressure test asks for one.
    always @(negedge aclk) begin
        if (hold_off_active) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender keeps running freely.
    initial begin
        forever begin
            wait (hold_off_request > 0);
            @(posedge aclk);
            hold_off_active = 1'b1;
            repeat (hold_off_request) @(posedge aclk);
            hold_off_active  = 1'b0;
            hold_off_request = 0;
        end
    end

    function automatic in_beat_t sample_of(logic [DATA_W-1:0] cmd, logic [DATA_W-1:0] slip,
                                           logic [DATA_W-1:0] speed);
        in_beat_t b;
        b.driver_pressure = cmd;
        b.wheel_slip      = slip;
        b.vehicle_speed   = speed;
        return b;
    endfunction

    // Offers one input beat, after a random idle gap, and returns on the edge
    // that takes it. Valid is only lowered on a gap, so it never drops and rises
    // within one step.
    task automatic send_sample(in_beat_t b);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops sending and waits until every owed beat has come back.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // One register access: setup cycle, then access cycle until pready.
    task automatic apb_transfer(input bit is_write, input logic [2:0] idx,
                                input logic [DATA_W-1:0] wdata,
                                output logic [APB_W-1:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= APB_W'(wdata);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (is_write) begin
            model_regs[idx] = wdata;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_register(logic [2:0] idx);
        logic [APB_W-1:0] rd;
        apb_transfer(1'b0, idx, '0, rd);
        if (rd !== APB_W'(model_regs[idx])) begin
            report_mismatch("register readback", model_regs[idx], rd);
        end
    endtask

    // Writes a register and reads it back.
    task automatic program_register(logic [2:0] idx, logic [DATA_W-1:0] value);
        logic [APB_W-1:0] unused;
        apb_transfer(1'b1, idx, value, unused);
        check_register(idx);
    endtask

    task automatic set_thresholds(logic [DATA_W-1:0] cutoff, logic [DATA_W-1:0] high_lvl,
                                  logic [DATA_W-1:0] top_lvl, logic [DATA_W-1:0] bottom_lvl,
                                  logic [DATA_W-1:0] release_lvl, logic [DATA_W-1:0] inc,
                                  logic [DATA_W-1:0] dec, logic [DATA_W-1:0] floor_lvl);
        program_register(REG_SPEED_CUTOFF, cutoff);
        program_register(REG_SLIP_HIGH, high_lvl);
        program_register(REG_SLIP_BAND_TOP, top_lvl);
        program_register(REG_SLIP_BAND_BOTTOM, bottom_lvl);
        program_register(REG_SLIP_RELEASE, release_lvl);
        program_register(REG_BUILD_INCREMENT, inc);
        program_register(REG_DUMP_DECREMENT, dec);
        program_register(REG_PRESSURE_FLOOR, floor_lvl);
    endtask

    // A slip value within two counts of a threshold, kept in range.
    function automatic logic [DATA_W-1:0] near(logic [DATA_W-1:0] level);
        int v;
        v = int'(level) + int'($urandom_range(4)) - 2;
        if (v < 0) begin
            v = 0;
        end
        if (v > 65535) begin
            v = 65535;
        end
        return v[DATA_W-1:0];
    endfunction

    // Mostly samples that keep modulation on and sit near the slip thresholds,
    // so the machine walks all its phases; noise beats are fully random.
    function automatic in_beat_t random_sample(bit noise);
        in_beat_t b;
        b.driver_pressure = DATA_W'($urandom);
        b.wheel_slip      = DATA_W'($urandom);
        b.vehicle_speed   = DATA_W'($urandom);
        if (!noise) begin
            if ($urandom_range(9) < 7) begin
                b.driver_pressure = DATA_W'($urandom_range(65535, 16384));
            end
            case ($urandom_range(4))
                0: b.wheel_slip = near(model_regs[REG_SLIP_HIGH]);
                1: b.wheel_slip = near(model_regs[REG_SLIP_BAND_TOP]);
                2: b.wheel_slip = near(model_regs[REG_SLIP_BAND_BOTTOM]);
                3: b.wheel_slip = near(model_regs[REG_SLIP_RELEASE]);
                default: ;
            endcase
            if ($urandom_range(9) != 0) begin
                b.vehicle_speed = DATA_W'($urandom_range(65535, model_regs[REG_SPEED_CUTOFF]));
            end
        end
        return b;
    endfunction

    // Every register must come out of reset at its documented value.
    task automatic test_reset_values();
        for (int i = 0; i < NUM_REGS; i++) begin
            check_register(i[2:0]);
        end
    endtask

    // Below the cutoff the command passes straight through; at the cutoff the
    // machine runs.
    task automatic test_low_speed();
        send_sample(sample_of(16'hFFFF, 16'hFFFF, 16'h0000));
        send_sample(sample_of(16'h1234, 16'h0000, 16'd1279));
        send_sample(sample_of(16'h2000, 16'd12000, 16'd1280));
    endtask

    // Walks every slip-threshold transition the reset thresholds allow, edges included.
    task automatic test_phase_walk();
        send_sample(sample_of(16'hFFFF, 16'd0, 16'hFFFF));      // normal to build
        send_sample(sample_of(16'hFFFF, 16'd16384, 16'hFFFF));  // build stays on band top
        send_sample(sample_of(16'hFFFF, 16'hFFFF, 16'hFFFF));   // build holds before dumping
        send_sample(sample_of(16'hFFFF, 16'd9830, 16'hFFFF));   // hold stays on band bottom
        send_sample(sample_of(16'hFFFF, 16'd19662, 16'hFFFF));  // hold to dump
        send_sample(sample_of(16'hFFFF, 16'd6554, 16'hFFFF));   // dump stays at release
        send_sample(sample_of(16'hFFFF, 16'd6553, 16'hFFFF));   // dump to build
        send_sample(sample_of(16'hFFFF, 16'd16385, 16'hFFFF));  // build to hold
        send_sample(sample_of(16'hFFFF, 16'd9829, 16'hFFFF));   // hold to build
        send_sample(sample_of(16'h0100, 16'd0, 16'd0));         // back to normal
        send_sample(sample_of(16'h0000, 16'd19662, 16'hFFFF));  // normal to dump, zero command
        send_sample(sample_of(16'h5000, 16'd0, 16'd0));
        send_sample(sample_of(16'h5000, 16'd19661, 16'd1280)); // normal to hold
        send_sample(sample_of(16'h4000, 16'd0, 16'd0));
        send_sample(sample_of(16'h4000, 16'd9830, 16'hFFFF));   // normal stays
    endtask

    // Full-scale steps: the sum overshoots 16 bits and the difference goes
    // negative, and neither may wrap.
    task automatic test_wide_sum();
        drain_results();
        program_register(REG_BUILD_INCREMENT, 16'hFFFF);
        program_register(REG_DUMP_DECREMENT, 16'hFFFF);
        send_sample(sample_of(16'h8000, 16'd0, 16'd0));
        send_sample(sample_of(16'hFFFF, 16'd0, 16'hFFFF));
        send_sample(sample_of(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_sample(sample_of(16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_sample(sample_of(16'hFFFF, 16'hFFFF, 16'hFFFF));
        drain_results();
        program_register(REG_BUILD_INCREMENT, DEF_BUILD_INCREMENT);
        program_register(REG_DUMP_DECREMENT, DEF_DUMP_DECREMENT);
    endtask

    // A floor above the command loses to the command; at low speed it is unused.
    task automatic test_floor_above_command();
        drain_results();
        program_register(REG_PRESSURE_FLOOR, 16'h8000);
        send_sample(sample_of(16'h0100, 16'd0, 16'd0));
        send_sample(sample_of(16'h0100, 16'd0, 16'hFFFF));
        send_sample(sample_of(16'hFFFF, 16'd0, 16'hFFFF));
    endtask

    // Thresholds in the wrong order: the tests still run in their fixed order.
    task automatic test_bad_thresholds();
        drain_results();
        set_thresholds(DEF_SPEED_CUTOFF, 16'd1000, 16'd30000, 16'd40000, 16'd50000,
                       DEF_BUILD_INCREMENT, DEF_DUMP_DECREMENT, DEF_PRESSURE_FLOOR);
        send_sample(sample_of(16'hFFFF, 16'd0, 16'd0));
        send_sample(sample_of(16'hFFFF, 16'd500, 16'hFFFF));    // normal to build
        send_sample(sample_of(16'hFFFF, 16'd2000, 16'hFFFF));   // build to dump
        send_sample(sample_of(16'hFFFF, 16'd45000, 16'hFFFF));  // dump to build
        send_sample(sample_of(16'hFFFF, 16'd35000, 16'hFFFF));  // build to hold
    endtask

    // The receiver stops for a long stretch while the sender keeps offering
    // beats, so the block fills up and must hold off its input.
    task automatic test_backpressure();
        drain_results();
        set_thresholds(DEF_SPEED_CUTOFF, DEF_SLIP_HIGH, DEF_SLIP_BAND_TOP,
                       DEF_SLIP_BAND_BOTTOM, DEF_SLIP_RELEASE, DEF_BUILD_INCREMENT,
                       DEF_DUMP_DECREMENT, DEF_PRESSURE_FLOOR);
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_off_request = HOLD_OFF;
        repeat (50) send_sample(random_sample(1'b0));
        drain_results();
    endtask

    // Random traffic over several register settings, each under every idling
    // pattern in turn.
    task automatic test_random_traffic();
        int rel_lvl;
        int bot_lvl;
        int top_lvl;
        int high_lvl;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            drain_results();
            case (seg % 5)
                0: begin
                    set_thresholds(DEF_SPEED_CUTOFF, DEF_SLIP_HIGH, DEF_SLIP_BAND_TOP,
                                   DEF_SLIP_BAND_BOTTOM, DEF_SLIP_RELEASE,
                                   DEF_BUILD_INCREMENT, DEF_DUMP_DECREMENT,
                                   DEF_PRESSURE_FLOOR);
                end
                1: begin
                    set_thresholds('0, '0, '0, '0, '0, '0, '0, '0);
                end
                2: begin
                    set_thresholds('1, '1, '1, '1, '1, '1, '1, '1);
                end
                3: begin
                    set_thresholds(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
                                   DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
                                   DATA_W'($urandom), DATA_W'($urandom));
                end
                default: begin
                    // Sensible ordering with small steps, as a real tune would be.
                    rel_lvl  = $urandom_range(16000);
                    bot_lvl  = rel_lvl + $urandom_range(8000);
                    top_lvl  = bot_lvl + $urandom_range(8000);
                    high_lvl = top_lvl + $urandom_range(8000);
                    set_thresholds(DATA_W'($urandom_range(4000)), high_lvl[DATA_W-1:0],
                                   top_lvl[DATA_W-1:0], bot_lvl[DATA_W-1:0],
                                   rel_lvl[DATA_W-1:0], DATA_W'($urandom_range(600)),
                                   DATA_W'($urandom_range(600)), DATA_W'($urandom_range(2000)));
                end
            endcase
            case (seg / 5)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 51;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 51;
                end
                default: begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
            endcase
            repeat (SEG_SAMPLES) send_sample(random_sample($urandom_range(9) == 0));
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        m_ready = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        model_phase = PHASE_NORMAL;
        model_held  = '0;
        model_regs[REG_SPEED_CUTOFF]     = DEF_SPEED_CUTOFF;
        model_regs[REG_SLIP_HIGH]        = DEF_SLIP_HIGH;
        model_regs[REG_SLIP_BAND_TOP]    = DEF_SLIP_BAND_TOP;
        model_regs[REG_SLIP_BAND_BOTTOM] = DEF_SLIP_BAND_BOTTOM;
        model_regs[REG_SLIP_RELEASE]     = DEF_SLIP_RELEASE;
        model_regs[REG_BUILD_INCREMENT]  = DEF_BUILD_INCREMENT;
        model_regs[REG_DUMP_DECREMENT]   = DEF_DUMP_DECREMENT;
        model_regs[REG_PRESSURE_FLOOR]   = DEF_PRESSURE_FLOOR;

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_low_speed();
        test_phase_walk();
        test_wide_sum();
        test_floor_above_command();
        test_bad_thresholds();
        test_backpressure();
        test_random_traffic();
        drain_results();

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("abs_slip_band_pressure_fsm verification clean");
        end else begin
            $display("abs_slip_band_pressure_fsm verification failed");
        end
        $finish;
    end

endmodule
